FILE: hdl/bilinear_image_scaler_top_defines.svh
// ----------------------------------------------------------------------------
// bilinear_image_scaler_top_defines.svh
// Assertion macros for the scaler checker.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_SCALER_TOP_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define BIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define BIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, live through reset
`define BIS_ASSERT_NXT_ANY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

  localparam int SRC_SIZE_W = 9;
  localparam int TGT_SIZE_W = 13;
  localparam int COORD_W    = 12;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_TGT_WIDTH,
    REG_TGT_HEIGHT
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_H0,
    ST_H1,
    ST_V
  } state_t;

  // corner of the 2x2 source neighbourhood
  typedef enum logic [1:0] {
    Q_TL,
    Q_TR,
    Q_BL,
    Q_BR
  } quad_t;

  typedef enum logic [1:0] {
    LP_H0,
    LP_H1,
    LP_V
  } lerp_op_t;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    logic     div_sel_y;
    logic     step_x_load;
    logic     step_y_load;
    logic     mul_x;
    logic     mul_y;
    logic     pos_x;
    logic     pos_y;
    logic     rd_en;
    quad_t    rd_sel;
    logic     ld_en;
    quad_t    ld_sel;
    logic     lp_en;
    lerp_op_t lp_sel;
    logic     finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic req_go;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/bis_div.sv
// ----------------------------------------------------------------------------
// bis_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_div import bis_pkg::*; #(
  parameter int DIVW = 25,
  parameter int DSW  = 13
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DIVW-1:0] dividend,
  input  logic [DSW-1:0]  divisor,
  output logic [DIVW-1:0] quotient,
  output logic            done
);

  localparam int CW = $clog2(DIVW);

  logic            running;
  logic [CW-1:0]   cnt;
  logic [DSW-1:0]  rem;
  logic [DSW-1:0]  dvs;
  logic [DIVW-1:0] quo;
  logic [DSW:0]    rem_sh;
  logic            ge;
  logic [DSW-1:0]  rem_next;
  logic            last;

  assign last     = (cnt == CW'(DIVW - 1));
  assign rem_sh   = {rem, quo[DIVW-1]};
  assign ge       = (rem_sh >= {1'b0, dvs});
  assign rem_next = ge ? DSW'(rem_sh - {1'b0, dvs}) : rem_sh[DSW-1:0];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && last;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CW'(1);
        if (last) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      quo <= {quo[DIVW-2:0], ge};
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bis_ctrl.sv
// ----------------------------------------------------------------------------
// bis_ctrl
// Sequencer: step recompute, request schedule and handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_ctrl import bis_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       cfg_wr,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;
  logic   dirty;
  logic   dirty_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      dirty <= 1'b1;
    end else begin
      state <= state_next;
      dirty <= dirty_next;
    end
  end

  always_comb begin
    state_next = state;
    dirty_next = dirty;
    cmd        = '0;
    busy       = (state != ST_IDLE) || dirty;
    cmd.accept = start && !busy;
    unique case (state)
      ST_IDLE: begin
        if (dirty) begin
          cmd.div_start = 1'b1;
          dirty_next    = 1'b0;
          state_next    = ST_DIV_X;
        end else if (cmd.accept && status.req_go) begin
          state_next = ST_MUL_X;
        end
      end
      ST_DIV_X: begin
        if (status.div_done) begin
          cmd.step_x_load = 1'b1;
          cmd.div_start   = 1'b1;
          cmd.div_sel_y   = 1'b1;
          state_next      = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (status.div_done) begin
          cmd.step_y_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_MUL_X: begin
        cmd.mul_x  = 1'b1;
        state_next = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd.mul_y  = 1'b1;
        cmd.pos_x  = 1'b1;
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.pos_y  = 1'b1;
        state_next = ST_RD0;
      end
      ST_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = Q_TL;
        state_next = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = Q_TR;
        cmd.ld_en  = 1'b1;
        cmd.ld_sel = Q_TL;
        state_next = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = Q_BL;
        cmd.ld_en  = 1'b1;
        cmd.ld_sel = Q_TR;
        state_next = ST_RD3;
      end
      ST_RD3: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = Q_BR;
        cmd.ld_en  = 1'b1;
        cmd.ld_sel = Q_BL;
        state_next = ST_H0;
      end
      ST_H0: begin
        cmd.ld_en  = 1'b1;
        cmd.ld_sel = Q_BR;
        cmd.lp_en  = 1'b1;
        cmd.lp_sel = LP_H0;
        state_next = ST_H1;
      end
      ST_H1: begin
        cmd.lp_en  = 1'b1;
        cmd.lp_sel = LP_H1;
        state_next = ST_V;
      end
      ST_V: begin
        cmd.lp_en  = 1'b1;
        cmd.lp_sel = LP_V;
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // a size change always forces a fresh step computation
    if (cfg_wr) begin
      dirty_next = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bis_dp.sv
// ----------------------------------------------------------------------------
// bis_dp
// Datapath: image memory, step divider, positions and 4-lane interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_dp import bis_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH  = 256,
  parameter int MAX_SOURCE_HEIGHT = 256,
  parameter int MAX_TARGET_SIZE   = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  input  logic [SRC_SIZE_W-1:0] src_width,
  input  logic [SRC_SIZE_W-1:0] src_height,
  input  logic [TGT_SIZE_W-1:0] tgt_width,
  input  logic [TGT_SIZE_W-1:0] tgt_height,
  input  logic                  mode,
  input  logic [COORD_W-1:0]    coord_x,
  input  logic [COORD_W-1:0]    coord_y,
  input  logic [CHAN_W-1:0]     pixel_red,
  input  logic [CHAN_W-1:0]     pixel_green,
  input  logic [CHAN_W-1:0]     pixel_blue,
  input  logic [CHAN_W-1:0]     pixel_alpha,
  output logic [CHAN_W-1:0]     result_red,
  output logic [CHAN_W-1:0]     result_green,
  output logic [CHAN_W-1:0]     result_blue,
  output logic [CHAN_W-1:0]     result_alpha,
  output logic                  bad_request,
  output logic                  done
);

  localparam int SWW   = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int SHW   = $clog2(MAX_SOURCE_HEIGHT + 1);
  localparam int TWW   = $clog2(MAX_TARGET_SIZE + 1);
  localparam int XIW   = $clog2(MAX_SOURCE_WIDTH);
  localparam int YIW   = $clog2(MAX_SOURCE_HEIGHT);
  localparam int DIVW  = ((SWW > SHW) ? SWW : SHW) + FRAC_W;
  localparam int PXW   = COORD_W + DIVW;
  localparam int PIW   = PXW - FRAC_W;
  localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // floor(((b - a) * f) / 2^16) + a, one channel
  function automatic logic [CHAN_W-1:0] lerp8(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [FRAC_W-1:0] f);
    logic signed [CHAN_W:0]          d;
    logic signed [CHAN_W+FRAC_W+1:0] p;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, f});
    return a + p[CHAN_W+FRAC_W-1:FRAC_W];
  endfunction

  function automatic logic [PIX_W-1:0] lerp_pix(input logic [PIX_W-1:0]  a,
                                                input logic [PIX_W-1:0]  b,
                                                input logic [FRAC_W-1:0] f);
    logic [PIX_W-1:0] r;
    r = '0;
    for (int c = 0; c < PIX_W / CHAN_W; c++) begin
      r[c*CHAN_W +: CHAN_W] = lerp8(a[c*CHAN_W +: CHAN_W], b[c*CHAN_W +: CHAN_W], f);
    end
    return r;
  endfunction

  // effective sizes
  logic [SWW-1:0] sw;
  logic [SHW-1:0] sh;
  logic [TWW-1:0] tw;
  logic [TWW-1:0] th;

  always_comb begin
    priority if (src_width == '0) begin
      sw = SWW'(1);
    end else if (32'(src_width) > 32'(MAX_SOURCE_WIDTH)) begin
      sw = SWW'(MAX_SOURCE_WIDTH);
    end else begin
      sw = SWW'(src_width);
    end
    priority if (src_height == '0) begin
      sh = SHW'(1);
    end else if (32'(src_height) > 32'(MAX_SOURCE_HEIGHT)) begin
      sh = SHW'(MAX_SOURCE_HEIGHT);
    end else begin
      sh = SHW'(src_height);
    end
    priority if (tgt_width == '0) begin
      tw = TWW'(1);
    end else if (32'(tgt_width) > 32'(MAX_TARGET_SIZE)) begin
      tw = TWW'(MAX_TARGET_SIZE);
    end else begin
      tw = TWW'(tgt_width);
    end
    priority if (tgt_height == '0) begin
      th = TWW'(1);
    end else if (32'(tgt_height) > 32'(MAX_TARGET_SIZE)) begin
      th = TWW'(MAX_TARGET_SIZE);
    end else begin
      th = TWW'(tgt_height);
    end
  end

  logic wr_ok;
  logic req_bad;

  assign wr_ok   = (32'(coord_x) < 32'(sw)) && (32'(coord_y) < 32'(sh));
  assign req_bad = (32'(coord_x) >= 32'(tw)) || (32'(coord_y) >= 32'(th));

  // step divider
  logic [DIVW-1:0] div_dividend;
  logic [TWW-1:0]  div_divisor;
  logic [DIVW-1:0] div_quo;
  logic            div_done;

  assign div_dividend = cmd.div_sel_y ? DIVW'({sh, {FRAC_W{1'b0}}})
                                      : DIVW'({sw, {FRAC_W{1'b0}}});
  assign div_divisor  = cmd.div_sel_y ? th : tw;

  bis_div #(
    .DIVW (DIVW),
    .DSW  (TWW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  assign status.div_done = div_done;
  assign status.req_go   = mode && !req_bad;

  // coordinates, steps and positions
  logic [COORD_W-1:0] xc;
  logic [COORD_W-1:0] yc;
  logic [DIVW-1:0]    xstep;
  logic [DIVW-1:0]    ystep;
  logic [COORD_W-1:0] mul_a;
  logic [DIVW-1:0]    mul_b;
  logic [PXW-1:0]     prod;
  logic [PXW-1:0]     px;
  logic [PXW-1:0]     py;

  assign mul_a = cmd.mul_y ? yc : xc;
  assign mul_b = cmd.mul_y ? ystep : xstep;
  assign prod  = mul_a * mul_b;

  logic [SWW-1:0]    sw_m1;
  logic [SHW-1:0]    sh_m1;
  logic [XIW-1:0]    x_last;
  logic [YIW-1:0]    y_last;
  logic [PIW-1:0]    xi_full;
  logic [PIW-1:0]    yi_full;
  logic [XIW-1:0]    xi_c;
  logic [XIW-1:0]    xn_c;
  logic [YIW-1:0]    yi_c;
  logic [YIW-1:0]    yn_c;

  assign sw_m1   = sw - SWW'(1);
  assign sh_m1   = sh - SHW'(1);
  assign x_last  = XIW'(sw_m1);
  assign y_last  = YIW'(sh_m1);
  assign xi_full = px[PXW-1:FRAC_W];
  assign yi_full = py[PXW-1:FRAC_W];
  // last column or row has no neighbour: pair it with itself
  assign xi_c    = (xi_full >= PIW'(sw_m1)) ? x_last : XIW'(xi_full);
  assign xn_c    = (xi_c < x_last) ? xi_c + XIW'(1) : xi_c;
  assign yi_c    = (yi_full >= PIW'(sh_m1)) ? y_last : YIW'(yi_full);
  assign yn_c    = (yi_c < y_last) ? yi_c + YIW'(1) : yi_c;

  logic [XIW-1:0]    xi;
  logic [XIW-1:0]    xn;
  logic [YIW-1:0]    yi;
  logic [YIW-1:0]    yn;
  logic [FRAC_W-1:0] fx;
  logic [FRAC_W-1:0] fy;

  always_ff @(posedge clk) begin
    if (cmd.accept && mode) begin
      xc <= coord_x;
      yc <= coord_y;
    end
    if (cmd.step_x_load) begin
      xstep <= div_quo;
    end
    if (cmd.step_y_load) begin
      ystep <= div_quo;
    end
    if (cmd.mul_x) begin
      px <= prod;
    end
    if (cmd.mul_y) begin
      py <= prod;
    end
    if (cmd.pos_x) begin
      xi <= xi_c;
      xn <= xn_c;
      fx <= px[FRAC_W-1:0];
    end
    if (cmd.pos_y) begin
      yi <= yi_c;
      yn <= yn_c;
      fy <= py[FRAC_W-1:0];
    end
  end

  // image memory, single port
  logic [PIX_W-1:0] mem [DEPTH];
  logic             mem_we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    addr;
  logic [PIX_W-1:0] wdata;
  logic [PIX_W-1:0] rdata;
  logic [XIW-1:0]   rd_col;
  logic [YIW-1:0]   rd_row;

  assign mem_we = cmd.accept && !mode && wr_ok;
  assign wdata  = {pixel_alpha, pixel_blue, pixel_green, pixel_red};
  assign waddr  = AW'(coord_y[YIW-1:0]) * AW'(MAX_SOURCE_WIDTH) + AW'(coord_x[XIW-1:0]);

  always_comb begin
    unique case (cmd.rd_sel)
      Q_TL: begin
        rd_col = xi;
        rd_row = yi;
      end
      Q_TR: begin
        rd_col = xn;
        rd_row = yi;
      end
      Q_BL: begin
        rd_col = xi;
        rd_row = yn;
      end
      Q_BR: begin
        rd_col = xn;
        rd_row = yn;
      end
      default: begin
        rd_col = xi;
        rd_row = yi;
      end
    endcase
  end

  assign raddr = AW'(rd_row) * AW'(MAX_SOURCE_WIDTH) + AW'(rd_col);
  assign addr  = mem_we ? waddr : raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[addr];
    end
  end

  // neighbourhood and interpolation
  logic [PIX_W-1:0]  p_tl;
  logic [PIX_W-1:0]  p_tr;
  logic [PIX_W-1:0]  p_bl;
  logic [PIX_W-1:0]  p_br;
  logic [PIX_W-1:0]  h0;
  logic [PIX_W-1:0]  h1;
  logic [PIX_W-1:0]  lp_a;
  logic [PIX_W-1:0]  lp_b;
  logic [FRAC_W-1:0] lp_f;
  logic [PIX_W-1:0]  lp_out;

  always_comb begin
    unique case (cmd.lp_sel)
      LP_H0: begin
        lp_a = p_tl;
        lp_b = p_tr;
        lp_f = fx;
      end
      LP_H1: begin
        lp_a = p_bl;
        lp_b = p_br;
        lp_f = fx;
      end
      LP_V: begin
        lp_a = h0;
        lp_b = h1;
        lp_f = fy;
      end
      default: begin
        lp_a = h0;
        lp_b = h1;
        lp_f = fy;
      end
    endcase
  end

  assign lp_out = lerp_pix(lp_a, lp_b, lp_f);

  always_ff @(posedge clk) begin
    if (cmd.ld_en) begin
      unique case (cmd.ld_sel)
        Q_TL:    p_tl <= rdata;
        Q_TR:    p_tr <= rdata;
        Q_BL:    p_bl <= rdata;
        Q_BR:    p_br <= rdata;
        default: p_tl <= rdata;
      endcase
    end
    if (cmd.lp_en && (cmd.lp_sel == LP_H0)) begin
      h0 <= lp_out;
    end
    if (cmd.lp_en && (cmd.lp_sel == LP_H1)) begin
      h1 <= lp_out;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish || (cmd.accept && mode && req_bad);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result_red   <= lp_out[0*CHAN_W +: CHAN_W];
      result_green <= lp_out[1*CHAN_W +: CHAN_W];
      result_blue  <= lp_out[2*CHAN_W +: CHAN_W];
      result_alpha <= lp_out[3*CHAN_W +: CHAN_W];
      bad_request  <= 1'b0;
    end else if (cmd.accept && mode && req_bad) begin
      result_red   <= '0;
      result_green <= '0;
      result_blue  <= '0;
      result_alpha <= '0;
      bad_request  <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bilinear_image_scaler_top.sv
// ----------------------------------------------------------------------------
// bilinear_image_scaler_top
// Write beat: one per cycle while busy is low. Request beat: result strobe
// after acceptance (four single-port memory reads, one shared multiplier,
// three interpolator passes); an out-of-range request strobes done in the
// cycle after acceptance. After reset and after any size write, busy
// holds while the bit-serial divider rebuilds both steps. Synchronous
// reset; image memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_image_scaler_top import bis_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH  = 256,
  parameter int MAX_SOURCE_HEIGHT = 256,
  parameter int MAX_TARGET_SIZE   = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  mode,
  input  logic [COORD_W-1:0]    coord_x,
  input  logic [COORD_W-1:0]    coord_y,
  input  logic [CHAN_W-1:0]     pixel_red,
  input  logic [CHAN_W-1:0]     pixel_green,
  input  logic [CHAN_W-1:0]     pixel_blue,
  input  logic [CHAN_W-1:0]     pixel_alpha,
  // result channel, no back-pressure
  output logic                  done,
  output logic [CHAN_W-1:0]     result_red,
  output logic [CHAN_W-1:0]     result_green,
  output logic [CHAN_W-1:0]     result_blue,
  output logic [CHAN_W-1:0]     result_alpha,
  output logic                  bad_request,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // --------------------------------------------------------------------------
  // Size registers, one per 32-bit word. Raw values are kept; clamping to the
  // legal range happens where they are used.
  // --------------------------------------------------------------------------
  logic [SRC_SIZE_W-1:0] src_width;
  logic [SRC_SIZE_W-1:0] src_height;
  logic [TGT_SIZE_W-1:0] tgt_width;
  logic [TGT_SIZE_W-1:0] tgt_height;
  logic                  cfg_wr;
  reg_idx_t              reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SRC_SIZE_W'(256);
      src_height <= SRC_SIZE_W'(256);
      tgt_width  <= TGT_SIZE_W'(256);
      tgt_height <= TGT_SIZE_W'(256);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SRC_WIDTH:  src_width  <= pwdata[SRC_SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height <= pwdata[SRC_SIZE_W-1:0];
        REG_TGT_WIDTH:  tgt_width  <= pwdata[TGT_SIZE_W-1:0];
        REG_TGT_HEIGHT: tgt_height <= pwdata[TGT_SIZE_W-1:0];
        default:        src_width  <= src_width;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SRC_WIDTH:  prdata = APB_DATA_W'(src_width);
      REG_SRC_HEIGHT: prdata = APB_DATA_W'(src_height);
      REG_TGT_WIDTH:  prdata = APB_DATA_W'(tgt_width);
      REG_TGT_HEIGHT: prdata = APB_DATA_W'(tgt_height);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller and datapath. From the datapath the controller only sees
  // divider completion and whether an accepted beat is an in-range request;
  // everything else is steered by the command struct.
  // --------------------------------------------------------------------------
  ctrl_cmd_t  cmd;
  dp_status_t status;

  bis_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cfg_wr (cfg_wr),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  bis_dp #(
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
    .MAX_TARGET_SIZE   (MAX_TARGET_SIZE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .src_width    (src_width),
    .src_height   (src_height),
    .tgt_width    (tgt_width),
    .tgt_height   (tgt_height),
    .mode         (mode),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .pixel_red    (pixel_red),
    .pixel_green  (pixel_green),
    .pixel_blue   (pixel_blue),
    .pixel_alpha  (pixel_alpha),
    .result_red   (result_red),
    .result_green (result_green),
    .result_blue  (result_blue),
    .result_alpha (result_alpha),
    .bad_request  (bad_request),
    .done         (done)
  );

endmodule

`default_nettype wire

FILE: hdl/bis_chk.sv
// ----------------------------------------------------------------------------
// bis_chk
// Port-level checks on the scaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bilinear_image_scaler_top_defines.svh"

module bis_chk import bis_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  mode,
  input wire logic                  done,
  input wire logic [CHAN_W-1:0]     result_red,
  input wire logic [CHAN_W-1:0]     result_green,
  input wire logic [CHAN_W-1:0]     result_blue,
  input wire logic [CHAN_W-1:0]     result_alpha,
  input wire logic                  bad_request,
  input wire logic                  psel,
  input wire logic                  penable,
  input wire logic                  pwrite,
  input wire logic                  pready
);

  // rejected request carries an all-zero pixel
  `BIS_ASSERT_IMP(a_bad_zero, done && bad_request, (result_red == 0) && (result_green == 0) && (result_blue == 0) && (result_alpha == 0), "bad request beat with non-zero pixel")

  // a pixel write never produces a result beat
  `BIS_ASSERT_NXT(a_wr_silent, start && !busy && !mode, !done, "result beat after a write")

  // a request is either rejected at once or keeps the block busy
  `BIS_ASSERT_NXT(a_req_next, start && !busy && mode, (done && bad_request) || busy, "request neither rejected nor in progress")

  // size write forces a step rebuild
  `BIS_ASSERT_NXT(a_cfg_busy, psel && penable && pwrite && pready, busy, "size write left block idle")

  // steps are rebuilt straight out of reset
  `BIS_ASSERT_NXT_ANY(a_rst_busy, rst, busy, "not busy after reset")

endmodule

bind bilinear_image_scaler_top bis_chk u_chk (.*);

`default_nettype wire
